### hdl/circular_deque_macros.svh
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cdq_pkg.sv
package cdq_pkg;

    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 4;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
    } t_cell_op;

endpackage

### hdl/cdq_cell.sv
module cdq_cell
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IDX   = 0
) (
    input  logic                         i_clk,
    input  t_cell_op                     i_op,
    input  logic [$clog2(DEPTH+1)-1:0]   i_held,
    input  logic [WORD_W-1:0]            i_value,
    input  logic [WORD_W-1:0]            i_left,
    input  logic [WORD_W-1:0]            i_right,
    output logic [WORD_W-1:0]            o_data,
    output logic [WORD_W-1:0]            o_tap
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] MY_POS  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        priority if (i_op.push_front) begin
            n_data = i_left;
        end else if (i_op.push_rear && (i_held == MY_POS)) begin
            n_data = i_value;
        end else if (i_op.pop_front) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // last occupied cell offers its word for a rear pop
    assign o_tap  = (i_held == MY_NEXT) ? r_data : '0;

endmodule

### hdl/circular_deque.sv
// Double-ended queue held as a row of shifting cells, front at cell 0.
// The result and its status and flags are registered as the word is accepted.
// Throughput: one word per cycle while the input is not stalled; each cell shifts or loads as a word is accepted.
// Input stalls only while a finished result is held by output stall.
// Reset (sync, active low) empties the deque; cell contents are not cleared.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_value_out,
    output logic [1:0]         o_status,
    output logic [3:0]         o_count,
    output logic               o_is_empty,
    output logic               o_is_full
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]        r_held;
    logic [CW-1:0]        n_held;
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_value_out;
    logic [1:0]           r_status;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_is_empty;
    logic                 r_is_full;

    logic                 accept;
    logic                 is_push;
    logic                 empty_now;
    logic                 full_now;
    logic [1:0]           status;
    logic [WORD_W-1:0]    pop_word;
    logic [WORD_W-1:0]    rear_word;
    logic [CW+COUNT_W-1:0] held_ext;
    t_cell_op             op;

    logic [WORD_W-1:0] cell_data [DEPTH];
    logic [WORD_W-1:0] cell_tap  [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_push    = (i_mode == MODE_PUSH_FRONT) || (i_mode == MODE_PUSH_REAR);
    assign empty_now  = (r_held == '0);
    assign full_now   = (r_held == FULL_CNT);

    always_comb begin
        status = ST_DONE;
        if (is_push && full_now) begin
            status = ST_FULL;
        end else if (!is_push && empty_now) begin
            status = ST_EMPTY;
        end
    end

    always_comb begin
        op.push_front = accept && (status == ST_DONE) && (i_mode == MODE_PUSH_FRONT);
        op.push_rear  = accept && (status == ST_DONE) && (i_mode == MODE_PUSH_REAR);
        op.pop_front  = accept && (status == ST_DONE) && (i_mode == MODE_POP_FRONT);
    end

    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | cell_tap[i];
        end
    end

    always_comb begin
        n_held   = r_held;
        pop_word = '0;
        if (status == ST_DONE) begin
            unique case (i_mode)
                MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                    n_held = r_held + 1'b1;
                end
                MODE_POP_FRONT: begin
                    n_held   = r_held - 1'b1;
                    pop_word = cell_data[0];
                end
                MODE_POP_REAR: begin
                    n_held   = r_held - 1'b1;
                    pop_word = rear_word;
                end
                default: begin
                    n_held = r_held;
                end
            endcase
        end
    end

    assign held_ext = {{COUNT_W{1'b0}}, n_held};

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            cdq_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (op),
                .i_held  (r_held),
                .i_value (i_value_in),
                .i_left  ((g == 0) ? i_value_in : cell_data[(g == 0) ? 0 : g - 1]),
                .i_right ((g == DEPTH - 1) ? cell_data[g]
                                           : cell_data[(g == DEPTH - 1) ? g : g + 1]),
                .o_data  (cell_data[g]),
                .o_tap   (cell_tap[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_held <= n_held;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value_out <= pop_word;
            r_status    <= status;
            r_count     <= held_ext[COUNT_W-1:0];
            r_is_empty  <= (n_held == '0);
            r_is_full   <= (n_held == FULL_CNT);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_value_out;
    assign o_status    = r_status;
    assign o_count     = r_count;
    assign o_is_empty  = r_is_empty;
    assign o_is_full   = r_is_full;

endmodule

### hdl/cdq_checker.sv
`include "circular_deque_macros.svh"

module cdq_checker
    import cdq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] o_value_out,
    input  logic [1:0]         o_status,
    input  logic [3:0]         o_count,
    input  logic               o_is_empty,
    input  logic               o_is_full
);

    `CDQ_ASSERT_NOW(a_empty_flag, o_out_valid, o_is_empty == (o_count == 4'd0),
        "empty flag mismatch")

    `CDQ_ASSERT_NOW(a_full_reject, o_out_valid && (o_status == ST_FULL),
        o_is_full && !o_is_empty, "full reject while not full")

    `CDQ_ASSERT_NOW(a_empty_reject, o_out_valid && (o_status == ST_EMPTY),
        o_is_empty && (o_value_out == 32'sd0), "empty reject with data")

    `CDQ_ASSERT_NOW(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall,
        "input stalled without output backpressure")

    `CDQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_value_out) && $stable(o_status) && $stable(o_count),
        "stalled result changed")

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

### tb/circular_deque_checker.sv
`timescale 1ns / 100ps

module circular_deque_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_value_out,
    input  logic [1:0]         i_status,
    input  logic [3:0]         i_count,
    input  logic               i_is_empty,
    input  logic               i_is_full,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_full_rejects,
    output int                 o_empty_rejects,
    output int                 o_full_hits
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } t_deque_result;

    logic [WORD_W-1:0] slot_mem [DEPTH];
    int head_idx = 0;
    int tail_idx = 0;
    int n_held = 0;
    t_deque_result pending_results[$];

    int fails = 0;
    int checked = 0;
    int full_rejects = 0;
    int empty_rejects = 0;
    int full_hits = 0;

    function automatic t_deque_result deque_apply(logic [1:0] op, logic [WORD_W-1:0] word);
        t_deque_result r;
        r = '0;
        r.status = ST_DONE;
        if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
            if (n_held >= DEPTH) begin
                r.status = ST_FULL;
            end else if (op == MODE_PUSH_FRONT) begin
                head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                slot_mem[head_idx[IDX_W-1:0]] = word;
                n_held++;
            end else begin
                slot_mem[tail_idx[IDX_W-1:0]] = word;
                tail_idx = (tail_idx == DEPTH - 1) ? 0 : tail_idx + 1;
                n_held++;
            end
        end else if (n_held == 0) begin
            r.status = ST_EMPTY;
        end else if (op == MODE_POP_FRONT) begin
            r.value = slot_mem[head_idx[IDX_W-1:0]];
            head_idx = (head_idx == DEPTH - 1) ? 0 : head_idx + 1;
            n_held--;
        end else begin
            tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
            r.value = slot_mem[tail_idx[IDX_W-1:0]];
            n_held--;
        end
        r.count    = n_held[COUNT_W-1:0];
        r.is_empty = (n_held == 0);
        r.is_full  = (n_held == DEPTH);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            n_held   = 0;
            pending_results.delete();
        end else begin
            // drain first so a word accepted this edge never matches itself
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (pending_results.size() == 0) begin
                    $error("result word with no input word pending");
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("value_out", want.value, i_value_out);
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("count", 32'(want.count), 32'(i_count));
                    check_field("is_empty", 32'(want.is_empty), 32'(i_is_empty));
                    check_field("is_full", 32'(want.is_full), 32'(i_is_full));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = deque_apply(i_mode, i_value_in);
                if (want.status == ST_FULL) full_rejects++;
                if (want.status == ST_EMPTY) empty_rejects++;
                if (want.is_full) full_hits++;
                pending_results.push_back(want);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= pending_results.size();
        o_checked       <= checked;
        o_full_rejects  <= full_rejects;
        o_empty_rejects <= empty_rejects;
        o_full_hits     <= full_hits;
    end

endmodule

### tb/circular_deque_test.sv
`timescale 1ns / 100ps

module circular_deque_test;
    import cdq_pkg::*;

    localparam int DEPTH        = 8;
    localparam int RANDOM_WORDS = 1000;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_CYCLES = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic signed [31:0] value_in;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [3:0]         count;
    logic               is_empty;
    logic               is_full;

    int fail_count;
    int pending;
    int checked;
    int full_rejects;
    int empty_rejects;
    int full_hits;

    int words_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    always #10 clk = ~clk;

    circular_deque #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_mode      (mode),
        .i_value_in  (value_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_value_out (value_out),
        .o_status    (status),
        .o_count     (count),
        .o_is_empty  (is_empty),
        .o_is_full   (is_full)
    );

    circular_deque_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_mode          (mode),
        .i_value_in      (value_in),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_value_out     (value_out),
        .i_status        (status),
        .i_count         (count),
        .i_is_empty      (is_empty),
        .i_is_full       (is_full),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_rejects  (full_rejects),
        .o_empty_rejects (empty_rejects),
        .o_full_hits     (full_hits)
    );

    // entered and left at a falling edge
    task automatic send_word(logic [1:0] op, logic [31:0] word);
        in_valid <= 1'b1;
        mode     <= op;
        value_in <= word;
        do @(posedge clk); while (in_stall);
        words_sent++;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic run_directed();
        send_word(MODE_POP_FRONT, $urandom());
        send_word(MODE_POP_REAR, $urandom());
        send_word(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(MODE_PUSH_REAR, 32'h8000_0000);
        send_word(MODE_PUSH_FRONT, 32'h0000_0000);
        send_word(MODE_PUSH_REAR, 32'hFFFF_FFFF);
        send_word(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
        send_word(MODE_PUSH_REAR, 32'h5555_5555);
        send_word(MODE_PUSH_FRONT, 32'h0000_0001);
        send_word(MODE_PUSH_REAR, 32'h0000_0002);
        send_word(MODE_PUSH_FRONT, 32'h1234_5678);
        send_word(MODE_PUSH_REAR, 32'hFEDC_BA98);
        send_word(MODE_POP_FRONT, $urandom());
        send_word(MODE_POP_REAR, $urandom());
        send_word(MODE_POP_FRONT, $urandom());
        send_word(MODE_POP_REAR, $urandom());
        send_word(MODE_POP_FRONT, $urandom());
        send_word(MODE_POP_REAR, $urandom());
        send_word(MODE_POP_FRONT, $urandom());
        send_word(MODE_POP_REAR, $urandom());
        send_word(MODE_PUSH_REAR, 32'hC0DE_0001);
        send_word(MODE_POP_FRONT, $urandom());
        send_word(MODE_PUSH_FRONT, 32'hC0DE_0002);
        send_word(MODE_POP_REAR, $urandom());
    endtask

    // segments lean toward filling, draining or neither so both ends get hit
    task automatic run_random();
        int push_pct;
        int seg_left;
        bit is_push;
        bit rear_side;
        logic [1:0] op;
        push_pct = 50;
        seg_left = 0;
        repeat (RANDOM_WORDS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(5, 30);
                case ($urandom_range(0, 2))
                    0: push_pct = 80;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            seg_left--;
            is_push   = ($urandom_range(0, 99) < push_pct);
            rear_side = 1'($urandom_range(0, 1));
            if (is_push) op = rear_side ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            else op = rear_side ? MODE_POP_REAR : MODE_POP_FRONT;
            send_word(op, $urandom());
        end
    endtask

    initial begin
        int seg;
        int seg_len;
        int style;
        out_stall = 1'b0;
        seg = 0;
        wait (rst_n === 1'b1);
        forever begin
            seg++;
            if (seg % 12 == 3) begin
                // long hold-off so the deque backs up and stalls its input
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end else begin
                seg_len = $urandom_range(10, 60);
                style = $urandom_range(0, 3);
                for (int k = 0; k < seg_len; k++) begin
                    @(negedge clk);
                    case (style)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= k[0];
                    endcase
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        mode     = MODE_PUSH_FRONT;
        value_in = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Deque run: %0d words sent, %0d results checked, reached full %0d times",
                 words_sent, checked, full_hits);
        $display("Rejected pushes when full: %0d, rejected pops when empty: %0d",
                 full_rejects, empty_rejects);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/cdq_pkg.sv
hdl/cdq_cell.sv
hdl/circular_deque.sv
hdl/cdq_checker.sv
tb/circular_deque_checker.sv
tb/circular_deque_test.sv
